// File: hw/rtl/etht_pkg.sv
// Shared types and constants of the energy threshold hit time block.
// Used by etht_isqrt, energy_threshold_hit_time_core and the testbench; depends on nothing.
`default_nettype none

package etht_pkg;

    // Contribution store geometry.
    localparam int MAX_CONTRIB = 64;
    localparam int ADDR_W      = $clog2(MAX_CONTRIB);
    localparam int CNT_W       = ADDR_W + 1;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int ENERGY_W = 24;
    localparam int POS_W    = 16;
    localparam int GAIN_W   = 32;
    localparam int THR_W    = 48;
    localparam int FPM_W    = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_RATE = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 32'd491520000;
    localparam logic [THR_W-1:0]  THRESH_RESET = 48'd102400000000;
    localparam logic [FPM_W-1:0]  FLIGHT_RESET = 16'd3498;

    // 999 ns in units of 1/1024 ns.
    localparam logic [TIME_W-1:0] SENTINEL_TIME = 32'd1022976;

    // Square root: radicand is the 32 bit sum of squares shifted up by 20.
    localparam int SUMSQ_W = 32;
    localparam int RAD_W   = SUMSQ_W + 20;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int STEP_W  = $clog2(ROOT_W);

    // Shared multiplier.
    localparam int MUL_W = 32;

    // Flight time: root times rate stays below 2^42, rounded and shifted by 20.
    localparam int FLT_PROD_W = ROOT_W + FPM_W;
    localparam int FLIGHT_W   = FLT_PROD_W - 20;

    // Running energy sum: below threshold plus one product.
    localparam int PROD_E_W = ENERGY_W + GAIN_W;
    localparam int SUM_W    = PROD_E_W + 1;

    typedef struct packed {
        logic [TIME_W-1:0]   time_val;
        logic [ENERGY_W-1:0] energy;
    } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/etht_isqrt.sv
// Iterative integer square root, one result bit per clock cycle.
// Depends on etht_pkg for the radicand and root widths.
`default_nettype none

module etht_isqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [etht_pkg::RAD_W-1:0]    radicand,
    output logic                               done,
    output logic [etht_pkg::ROOT_W-1:0]        root
);

    logic [etht_pkg::RAD_W-1:0]   rem_reg,  rem_next;
    logic [etht_pkg::RAD_W:0]     res_reg,  res_next;
    logic [etht_pkg::RAD_W:0]     bit_reg,  bit_next;
    logic [etht_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [etht_pkg::RAD_W:0]     trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = (etht_pkg::RAD_W+1)'(1) << (etht_pkg::RAD_W - 2);
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Classic digit-pair method: try the next root bit.
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[etht_pkg::RAD_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg + 1'b1;
            if (step_reg == etht_pkg::STEP_W'(etht_pkg::ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign root = res_reg[etht_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/energy_threshold_hit_time_core.sv
// Top level of the energy threshold hit time block: time-ordered contribution
// store, shared multiplier and sequencer. Depends on etht_pkg and etht_isqrt.
//
// Each beat on the s_ channel carries one energy contribution of a hit; s_tlast
// marks the final one, whose position fields give the hit position. Every
// contribution is inserted into a 64 entry store kept in ascending time order;
// contributions beyond 64 are dropped and reported as truncated. After the last
// beat the block squares the position on a shared 32 x 32 multiplier, takes an
// iterative square root for the flight time, then walks the store summing
// calibrated energies until the threshold is exceeded and sends one m_ beat.
// An item goes straight into an empty store; else each stored entry later than
// it is shifted up one slot first; a full store drops it. The last beat then
// squares the position, takes the square root and flight time, sums entries up
// to the crossing and loads the output register, on one store read port and
// one multiplier; s_tready is low throughout. If the receiver stalls, the result
// waits in the output register and the next hit runs until its own result is
// due, then waits for that beat. Reset (aresetn, synchronous, active low)
// empties the store, clears the truncation flag and the output valid, and
// restores the register defaults. The configuration channel is always ready; it
// must be written only while idle, and the block itself does not enforce this.
`default_nettype none

module energy_threshold_hit_time_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Contributions.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // cont_time[31:0], cont_energy[55:32], pos_x[71:56], pos_y[87:72], pos_z[103:88]
    input  wire logic [etht_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tlast,
    // Results.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // hit_time[31:0], reached[32], truncated[33], zero padding[39:34]
    output logic [etht_pkg::M_TDATA_W-1:0]          m_tdata,
    // Configuration writes.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [etht_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [etht_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_SH_RD   = 4'd1;
    localparam logic [ST_W-1:0] ST_SH_CMP  = 4'd2;
    localparam logic [ST_W-1:0] ST_INS     = 4'd3;
    localparam logic [ST_W-1:0] ST_SQX     = 4'd4;
    localparam logic [ST_W-1:0] ST_SQY     = 4'd5;
    localparam logic [ST_W-1:0] ST_SQZ     = 4'd6;
    localparam logic [ST_W-1:0] ST_SQE     = 4'd7;
    localparam logic [ST_W-1:0] ST_SQRT    = 4'd8;
    localparam logic [ST_W-1:0] ST_FLT     = 4'd9;
    localparam logic [ST_W-1:0] ST_FLT2    = 4'd10;
    localparam logic [ST_W-1:0] ST_ACC_RD  = 4'd11;
    localparam logic [ST_W-1:0] ST_ACC_MUL = 4'd12;
    localparam logic [ST_W-1:0] ST_ACC_ADD = 4'd13;
    localparam logic [ST_W-1:0] ST_OUT     = 4'd14;

    localparam int DIFF_W = etht_pkg::TIME_W + 2;

    // Configuration registers.
    logic [etht_pkg::GAIN_W-1:0] gain_reg;
    logic [etht_pkg::THR_W-1:0]  thr_reg;
    logic [etht_pkg::FPM_W-1:0]  fpm_reg;

    // Sequencer and hit state.
    logic [ST_W-1:0]              state_reg,  state_next;
    logic [etht_pkg::CNT_W-1:0]   count_reg,  count_next;
    logic                         ovf_reg,    ovf_next;
    logic [etht_pkg::ADDR_W-1:0]  ptr_reg,    ptr_next;
    logic [etht_pkg::CNT_W-1:0]   idx_reg,    idx_next;

    // Latched input beat.
    logic [etht_pkg::TIME_W-1:0]   t_reg,    t_next;
    logic [etht_pkg::ENERGY_W-1:0] e_reg,    e_next;
    logic [etht_pkg::POS_W-1:0]    px_reg,   px_next;
    logic [etht_pkg::POS_W-1:0]    py_reg,   py_next;
    logic [etht_pkg::POS_W-1:0]    pz_reg,   pz_next;
    logic                          last_reg, last_next;

    // Arithmetic state.
    logic [2*etht_pkg::MUL_W-1:0]   mul_reg;
    logic [etht_pkg::MUL_W-1:0]     mul_a, mul_b;
    logic [etht_pkg::SUMSQ_W-1:0]   sumsq_reg, sumsq_next;
    logic [etht_pkg::FLIGHT_W-1:0]  flight_reg, flight_next;
    logic [etht_pkg::SUM_W-1:0]     sum_reg, sum_next, sum_trial;
    logic [etht_pkg::TIME_W-1:0]    thold_reg, thold_next;
    logic [etht_pkg::FLT_PROD_W-1:0] flt_round;
    logic signed [DIFF_W-1:0]       diff;

    // Result staging and output register.
    logic [etht_pkg::TIME_W-1:0] res_reg, res_next;
    logic                        reached_reg, reached_next;
    logic                        m_valid_reg, m_valid_next;
    logic [etht_pkg::TIME_W-1:0] m_time_reg, m_time_next;
    logic                        m_reach_reg, m_reach_next;
    logic                        m_trunc_reg, m_trunc_next;

    // Contribution store, one read and one write port, registered read.
    etht_pkg::entry_t             store_mem [etht_pkg::MAX_CONTRIB];
    etht_pkg::entry_t             rd_q;
    etht_pkg::entry_t             wr_data;
    logic                         wr_en;
    logic [etht_pkg::ADDR_W-1:0]  wr_addr, rd_addr;

    // Square root unit.
    logic                           sqrt_start, sqrt_done;
    logic [etht_pkg::RAD_W-1:0]     sqrt_rad;
    logic [etht_pkg::ROOT_W-1:0]    sqrt_root;

    logic s_accept;
    logic [etht_pkg::POS_W-1:0] abs_x, abs_y, abs_z;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Magnitudes of the position; -32768 maps to 32768, still 16 bits unsigned.
    assign abs_x = px_reg[etht_pkg::POS_W-1] ? (~px_reg + 1'b1) : px_reg;
    assign abs_y = py_reg[etht_pkg::POS_W-1] ? (~py_reg + 1'b1) : py_reg;
    assign abs_z = pz_reg[etht_pkg::POS_W-1] ? (~pz_reg + 1'b1) : pz_reg;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = etht_pkg::MUL_W'(abs_x);
                mul_b = etht_pkg::MUL_W'(abs_x);
            end
            ST_SQY: begin
                mul_a = etht_pkg::MUL_W'(abs_y);
                mul_b = etht_pkg::MUL_W'(abs_y);
            end
            ST_SQZ: begin
                mul_a = etht_pkg::MUL_W'(abs_z);
                mul_b = etht_pkg::MUL_W'(abs_z);
            end
            ST_FLT: begin
                mul_a = etht_pkg::MUL_W'(sqrt_root);
                mul_b = etht_pkg::MUL_W'(fpm_reg);
            end
            ST_ACC_MUL: begin
                mul_a = etht_pkg::MUL_W'(rd_q.energy);
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_rad  = {sumsq_reg + mul_reg[etht_pkg::SUMSQ_W-1:0], 20'd0};
    assign flt_round = mul_reg[etht_pkg::FLT_PROD_W-1:0]
                       + (etht_pkg::FLT_PROD_W'(1) << 19);
    assign sum_trial = sum_reg + etht_pkg::SUM_W'(mul_reg[etht_pkg::PROD_E_W-1:0]);
    assign diff      = $signed({{2{thold_reg[etht_pkg::TIME_W-1]}}, thold_reg})
                       - $signed(DIFF_W'(flight_reg));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        t_next       = t_reg;
        e_next       = e_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        last_next    = last_reg;
        sumsq_next   = sumsq_reg;
        flight_next  = flight_reg;
        sum_next     = sum_reg;
        thold_next   = thold_reg;
        res_next     = res_reg;
        reached_next = reached_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_time_next  = m_time_reg;
        m_reach_next = m_reach_reg;
        m_trunc_next = m_trunc_reg;
        wr_en        = 1'b0;
        wr_addr      = ptr_reg;
        wr_data      = {t_reg, e_reg};
        rd_addr      = ptr_reg - 1'b1;
        sqrt_start   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    t_next    = s_tdata[31:0];
                    e_next    = s_tdata[55:32];
                    px_next   = s_tdata[71:56];
                    py_next   = s_tdata[87:72];
                    pz_next   = s_tdata[103:88];
                    last_next = s_tlast;
                    if (count_reg == etht_pkg::CNT_W'(etht_pkg::MAX_CONTRIB)) begin
                        // Store full: drop the contribution.
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? ST_SQX : ST_IDLE;
                    end else if (count_reg == '0) begin
                        ptr_next   = '0;
                        state_next = ST_INS;
                    end else begin
                        ptr_next   = count_reg[etht_pkg::ADDR_W-1:0];
                        state_next = ST_SH_RD;
                    end
                end
            end
            ST_SH_RD: begin
                rd_addr    = ptr_reg - 1'b1;
                state_next = ST_SH_CMP;
            end
            ST_SH_CMP: begin
                // rd_q holds entry ptr-1; fetch ptr-2 in case the shift continues.
                rd_addr = ptr_reg - 2'd2;
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                if ($signed(rd_q.time_val) > $signed(t_reg)) begin
                    wr_data  = rd_q;
                    ptr_next = ptr_reg - 1'b1;
                    if (ptr_reg == etht_pkg::ADDR_W'(1)) begin
                        state_next = ST_INS;
                    end
                end else begin
                    // Equal times stay ahead of the new entry.
                    wr_data    = {t_reg, e_reg};
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? ST_SQX : ST_IDLE;
                end
            end
            ST_INS: begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_data    = {t_reg, e_reg};
                count_next = count_reg + 1'b1;
                state_next = last_reg ? ST_SQX : ST_IDLE;
            end
            ST_SQX: begin
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sumsq_next = mul_reg[etht_pkg::SUMSQ_W-1:0];
                state_next = ST_SQZ;
            end
            ST_SQZ: begin
                sumsq_next = sumsq_reg + mul_reg[etht_pkg::SUMSQ_W-1:0];
                state_next = ST_SQE;
            end
            ST_SQE: begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    state_next = ST_FLT;
                end
            end
            ST_FLT: begin
                state_next = ST_FLT2;
            end
            ST_FLT2: begin
                flight_next  = flt_round[etht_pkg::FLT_PROD_W-1:20];
                sum_next     = '0;
                idx_next     = '0;
                res_next     = etht_pkg::SENTINEL_TIME;
                reached_next = 1'b0;
                state_next   = (count_reg == '0) ? ST_OUT : ST_ACC_RD;
            end
            ST_ACC_RD: begin
                rd_addr    = idx_reg[etht_pkg::ADDR_W-1:0];
                state_next = ST_ACC_MUL;
            end
            ST_ACC_MUL: begin
                thold_next = rd_q.time_val;
                state_next = ST_ACC_ADD;
            end
            ST_ACC_ADD: begin
                sum_next = sum_trial;
                if (sum_trial > etht_pkg::SUM_W'(thr_reg)) begin
                    reached_next = 1'b1;
                    // Only the lower bound can be passed: flight time is never negative.
                    if (diff[DIFF_W-1:etht_pkg::TIME_W-1] != '0
                        && diff[DIFF_W-1:etht_pkg::TIME_W-1] != '1) begin
                        res_next = {1'b1, {(etht_pkg::TIME_W-1){1'b0}}};
                    end else begin
                        res_next = diff[etht_pkg::TIME_W-1:0];
                    end
                    state_next = ST_OUT;
                end else if (idx_reg + 1'b1 == count_reg) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ACC_RD;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_time_next  = res_reg;
                    m_reach_next = reached_reg;
                    m_trunc_next = ovf_reg;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            gain_reg    <= etht_pkg::GAIN_RESET;
            thr_reg     <= etht_pkg::THRESH_RESET;
            fpm_reg     <= etht_pkg::FLIGHT_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    etht_pkg::CFG_CALIB_GAIN:  gain_reg <= cfg_data[etht_pkg::GAIN_W-1:0];
                    etht_pkg::CFG_THRESHOLD:   thr_reg  <= cfg_data[etht_pkg::THR_W-1:0];
                    etht_pkg::CFG_FLIGHT_RATE: fpm_reg  <= cfg_data[etht_pkg::FPM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        t_reg       <= t_next;
        e_reg       <= e_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        last_reg    <= last_next;
        mul_reg     <= mul_a * mul_b;
        sumsq_reg   <= sumsq_next;
        flight_reg  <= flight_next;
        sum_reg     <= sum_next;
        thold_reg   <= thold_next;
        res_reg     <= res_next;
        reached_reg <= reached_next;
        m_time_reg  <= m_time_next;
        m_reach_reg <= m_reach_next;
        m_trunc_reg <= m_trunc_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_q <= store_mem[rd_addr];
    end

    etht_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_trunc_reg, m_reach_reg, m_time_reg};

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for energy_threshold_hit_time_core: stream stimulus,
// register writes, a result predictor and a result checker.
// Depends on etht_pkg and the RTL of the block only.
`default_nettype none

module tb_top;

    import etht_pkg::*;

    // Register index that the block has no register for; writes to it are
    // expected to be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int HOLDOFF_CYCLES = 1500;  // long receiver stall of the pressure test
    localparam int STALL_LIMIT    = 5000;  // cycles without any accepted beat
    localparam int SETTLE_CYCLES  = 100;   // pause before a register write
    localparam int DRAIN_CYCLES   = 300;   // pause after the last expected result
    localparam int MAX_REPORTS    = 10;

    localparam longint HIT_TIME_MIN = -(longint'(1) << 31);
    localparam longint HIT_TIME_MAX = (longint'(1) << 31) - 1;

    // One expected or observed result beat.
    typedef struct packed {
        logic [TIME_W-1:0] hit_time;
        logic              reached;
        logic              truncated;
    } hit_verdict_t;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts at a
    // known value.
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // cont_time[31:0], cont_energy[55:32], pos_x[71:56], pos_y[87:72], pos_z[103:88]
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // hit_time[31:0], reached[32], truncated[33], zero padding[39:34]
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #5 aclk = ~aclk;

    energy_threshold_hit_time_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the time-ordered store, the
    // truncation flag and the three registers.
    // ------------------------------------------------------------------
    logic signed [TIME_W-1:0] ordered_time   [MAX_CONTRIB];
    logic [ENERGY_W-1:0]      ordered_energy [MAX_CONTRIB];
    int                       stored_count  = 0;
    bit                       dropped_any   = 1'b0;
    logic [GAIN_W-1:0]        calib_gain    = GAIN_RESET;
    logic [THR_W-1:0]         energy_limit  = THRESH_RESET;
    logic [FPM_W-1:0]         flight_rate   = FLIGHT_RESET;

    hit_verdict_t expected_hits[$];

    int  mismatch_count  = 0;
    int  results_seen    = 0;
    int  items_sent      = 0;
    int  energy_cap      = 255;     // upper bound of random raw energies
    bit  steady_traffic  = 1'b0;    // both sides stop idling while set
    bit  holdoff_pending = 1'b0;    // asks the receiver for its long stall

    // Floor of the square root, one result bit at a time from the top.
    // The radicand stays below 2^52, so the root fits in 26 bits.
    function automatic longint unsigned floor_root(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Takes one accepted contribution into the predicted store and, on the
    // final contribution of a hit, queues the result that the hit must give.
    function automatic void absorb_contribution(
        input logic signed [TIME_W-1:0] t,
        input logic [ENERGY_W-1:0]      e,
        input logic signed [POS_W-1:0]  px,
        input logic signed [POS_W-1:0]  py,
        input logic signed [POS_W-1:0]  pz,
        input logic                     is_last
    );
        int              slot;
        longint          sx, sy, sz, crossing;
        longint unsigned radicand, distance, flight, energy_sum, part;
        hit_verdict_t    verdict;

        // A full store drops the contribution, the final one included.
        if (stored_count >= MAX_CONTRIB) begin
            dropped_any = 1'b1;
        end else begin
            // Later times move up one slot; equal times stay in front.
            slot = stored_count;
            while (slot > 0 && ordered_time[slot-1] > t) begin
                ordered_time[slot]   = ordered_time[slot-1];
                ordered_energy[slot] = ordered_energy[slot-1];
                slot--;
            end
            ordered_time[slot]   = t;
            ordered_energy[slot] = e;
            stored_count++;
        end
        if (!is_last) begin
            return;
        end

        sx = px;
        sy = py;
        sz = pz;
        radicand = sx * sx + sy * sy + sz * sz;
        distance = floor_root(radicand << 20);
        flight   = (distance * flight_rate + (longint'(1) << 19)) >> 20;

        verdict.hit_time  = SENTINEL_TIME;
        verdict.reached   = 1'b0;
        verdict.truncated = dropped_any;
        energy_sum = 0;
        for (int i = 0; i < stored_count; i++) begin
            part = ordered_energy[i];
            part = part * calib_gain;
            energy_sum += part;
            if (energy_sum > energy_limit) begin
                crossing = ordered_time[i];
                crossing = crossing - longint'(flight);
                if (crossing < HIT_TIME_MIN) begin
                    crossing = HIT_TIME_MIN;
                end
                if (crossing > HIT_TIME_MAX) begin
                    crossing = HIT_TIME_MAX;
                end
                verdict.hit_time = crossing[TIME_W-1:0];
                verdict.reached  = 1'b1;
                break;
            end
        end
        expected_hits.insert(expected_hits.size(), verdict);
        stored_count = 0;
        dropped_any  = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. The task is entered at a rising edge and leaves at the
    // edge where its beat was accepted, with s_tvalid still high so that
    // back-to-back beats need no second assignment in one step.
    // ------------------------------------------------------------------
    task automatic send_contribution(
        input logic signed [TIME_W-1:0] t,
        input logic [ENERGY_W-1:0]      e,
        input logic signed [POS_W-1:0]  px,
        input logic signed [POS_W-1:0]  py,
        input logic signed [POS_W-1:0]  pz,
        input logic                     is_last
    );
        // Roughly one cycle in ten is left empty, unless traffic is steady.
        while (!steady_traffic && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px, e, t};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        absorb_contribution(t, e, px, py, pz, is_last);
    endtask

    // Drops the stream valid and waits for the block to go quiet: every
    // expected result in, then a margin for an insertion still shifting.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write beat; the predictor follows the write on acceptance.
    // The valid is low again by the time the task returns.
    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] value
    );
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_CALIB_GAIN:  calib_gain   = value[GAIN_W-1:0];
            CFG_THRESHOLD:   energy_limit = value[THR_W-1:0];
            CFG_FLIGHT_RATE: flight_rate  = value[FPM_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Writes all three registers. The unused upper data bits carry noise,
    // which the block has to ignore.
    task automatic apply_settings(
        input logic [GAIN_W-1:0] gain,
        input logic [THR_W-1:0]  limit,
        input logic [FPM_W-1:0]  rate
    );
        logic [31:0] noise;
        noise = $urandom;
        wait_until_idle();
        write_register(CFG_CALIB_GAIN, {noise[15:0], gain});
        write_register(CFG_THRESHOLD, limit);
        write_register(CFG_FLIGHT_RATE, {noise, rate});
    endtask

    // One hit of random length and content. Most hits are short; a few take up
    // to the whole store and some run past it. Times are mostly close together, so
    // that equal times and reordering are frequent.
    task automatic send_random_hit();
        int                       span;
        int                       pick;
        bit                       wide_times;
        bit                       near_origin;
        logic signed [TIME_W-1:0] base, t;
        logic [ENERGY_W-1:0]      e;
        logic signed [POS_W-1:0]  px, py, pz;

        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            span = $urandom_range(1, 6);
        end else if (pick < 90) begin
            span = $urandom_range(7, 30);
        end else if (pick < 97) begin
            span = $urandom_range(31, 64);
        end else begin
            span = $urandom_range(65, 80);
        end
        wide_times  = ($urandom_range(0, 3) == 0);
        near_origin = ($urandom_range(0, 3) == 0);
        base = $urandom;
        for (int k = 0; k < span; k++) begin
            t  = wide_times ? $urandom : base + $urandom_range(0, 15) * 64;
            e  = ENERGY_W'($urandom_range(0, energy_cap));
            px = POS_W'($urandom);
            py = POS_W'($urandom);
            pz = POS_W'($urandom);
            if (near_origin) begin
                px = px >>> 8;
                py = py >>> 8;
                pz = pz >>> 8;
            end
            send_contribution(t, e, px, py, pz, k == span - 1);
        end
    endtask

    // New random settings for a phase: the threshold is scaled to the mean
    // calibrated energy so that crossings fall early, late or never.
    task automatic randomise_settings();
        longint unsigned scaled;
        logic [GAIN_W-1:0] gain;
        logic [THR_W-1:0]  limit;

        case ($urandom_range(0, 3))
            0:       energy_cap = 255;
            1:       energy_cap = 4095;
            2:       energy_cap = 65535;
            default: energy_cap = 24'hFF_FFFF;
        endcase
        case ($urandom_range(0, 2))
            0:       gain = $urandom;
            1:       gain = $urandom_range(1, 4096);
            default: gain = GAIN_RESET;
        endcase
        scaled = energy_cap;
        scaled = scaled * gain;
        scaled = scaled * $urandom_range(0, 12) / 2;
        if (scaled > 48'hFFFF_FFFF_FFFF) begin
            scaled = 48'hFFFF_FFFF_FFFF;
        end
        limit = scaled[THR_W-1:0];
        if ($urandom_range(0, 7) == 0) begin
            limit[31:0]  = $urandom;
            limit[47:32] = 16'($urandom);
        end
        apply_settings(gain, limit, FPM_W'($urandom_range(0, 65535)));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset values of the registers: with the default gain a raw 209 eV
    // crosses the default threshold on its own and 208 eV does not.
    task automatic test_default_settings();
        // A single contribution at the origin: no flight correction.
        send_contribution(32'sd1000, 24'd209, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        // Just below the threshold: the 999 ns sentinel.
        send_contribution(32'sd1000, 24'd208, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        // Arrival order differs from time order; only the sorted walk
        // crosses at the latest contribution.
        send_contribution(32'sd500, 24'd150, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_contribution(32'sd100, 24'd100, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_contribution(32'sd300, 24'd100, 16'sd3, 16'sd4, 16'sd0, 1'b1);
        // Equal times stack behind each other.
        send_contribution(32'sd700, 24'd100, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_contribution(32'sd700, 24'd150, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_contribution(32'sd700, 24'd0, -16'sd7, 16'sd12, -16'sd250, 1'b1);
        // Latest time, largest energy, farthest positive corner.
        send_contribution(32'sh7FFF_FFFF, 24'hFF_FFFF,
                          16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        // Earliest time at the farthest negative corner: the flight
        // correction saturates at the bottom of the range.
        send_contribution(32'sh8000_0000, 24'hFF_FFFF,
                          16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        // Zero energies never cross.
        send_contribution(32'sd0, 24'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_contribution(32'sd0, 24'd0, 16'sh8000, 16'sh7FFF, 16'sd1, 1'b1);
        // Mixed signs on the position.
        send_contribution(-32'sd123456, 24'd5000, -16'sd1000, 16'sd2000, -16'sd3000, 1'b1);
    endtask

    // Register extremes, and a write to an index without a register.
    task automatic test_register_extremes();
        // Zero threshold: a zero energy is not above it, the next one is.
        apply_settings(32'hFFFF_FFFF, 48'd0, 16'hFFFF);
        send_contribution(32'sd10, 24'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_contribution(32'sd20, 24'd1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
        // Zero gain never reaches even a zero threshold.
        apply_settings(32'd0, 48'd0, 16'd0);
        send_contribution(32'sd30, 24'hFF_FFFF, 16'sd100, 16'sd100, 16'sd100, 1'b1);
        // Largest threshold: only large products cross it.
        apply_settings(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd1);
        send_contribution(32'sd5, 24'hFF_FFFF, 16'sd9, 16'sd9, 16'sd9, 1'b1);
        send_contribution(32'sd5, 24'd1, 16'sd9, 16'sd9, 16'sd9, 1'b1);
        // Back to the reset values, then a write the block must ignore.
        apply_settings(GAIN_RESET, THRESH_RESET, FLIGHT_RESET);
        write_register(CFG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
        send_contribution(32'sd40, 24'd209, 16'sd50, 16'sd60, 16'sd70, 1'b1);
    endtask

    // Hits that run past the store: the one whose last contribution is the
    // first dropped, and one that goes several beyond.
    task automatic test_store_overflow();
        logic signed [TIME_W-1:0] t;
        energy_cap = 255;
        for (int k = 0; k <= MAX_CONTRIB; k++) begin
            t = $urandom_range(0, 4095);
            send_contribution(t, ENERGY_W'($urandom_range(0, 40)), POS_W'($urandom),
                              POS_W'($urandom), POS_W'($urandom), k == MAX_CONTRIB);
        end
        for (int k = 0; k < MAX_CONTRIB + 8; k++) begin
            t = $urandom;
            send_contribution(t, ENERGY_W'($urandom_range(0, 255)), POS_W'($urandom),
                              POS_W'($urandom), POS_W'($urandom), k == MAX_CONTRIB + 7);
        end
    endtask

    // Random hits over a series of random settings. One phase runs with no
    // idle cycles on either side.
    task automatic test_random_hits();
        int phase_end;
        for (int phase = 0; phase < 10; phase++) begin
            randomise_settings();
            steady_traffic = (phase == 4);
            phase_end = items_sent + 100;
            while (items_sent < phase_end) begin
                send_random_hit();
            end
            steady_traffic = 1'b0;
        end
    endtask

    // The receiver stalls for a long stretch while short hits keep coming,
    // so the block fills its output and has to stop taking beats.
    task automatic test_output_backpressure();
        randomise_settings();
        holdoff_pending = 1'b1;
        for (int n = 0; n < 8; n++) begin
            for (int k = 0; k < 3; k++) begin
                send_contribution($urandom, ENERGY_W'($urandom_range(0, energy_cap)),
                                  POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                                  k == 2);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, plus the long stall on request. The stall
    // is counted here, in cycles, independent of the sender.
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (holdoff_pending) begin
                holdoff_pending = 1'b0;
                stall_left      = HOLDOFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (steady_traffic) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("result beat %0d: %s expected %0d, got %0d",
                     results_seen, what, want, got);
        end
    endtask

    // Every accepted result beat is checked against the oldest expectation,
    // field by field.
    always @(posedge aclk) begin : result_check
        hit_verdict_t got;
        hit_verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit_time  = m_tdata[31:0];
            got.reached   = m_tdata[32];
            got.truncated = m_tdata[33];
            if (expected_hits.size() == 0) begin
                flag_mismatch("unexpected beat, hit_time", 0, $signed(got.hit_time));
            end else begin
                want = expected_hits.pop_front();
                if (got.hit_time !== want.hit_time) begin
                    flag_mismatch("hit_time", $signed(want.hit_time), $signed(got.hit_time));
                end
                if (got.reached !== want.reached) begin
                    flag_mismatch("reached", want.reached, got.reached);
                end
                if (got.truncated !== want.truncated) begin
                    flag_mismatch("truncated", want.truncated, got.truncated);
                end
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run when no beat of any channel has been accepted
    // for far longer than the slowest correct hit or the long stall takes.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                    (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("energy_threshold_hit_time_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence: reset once, the tests in turn, then drain and report.
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_settings();
        test_register_extremes();
        test_store_overflow();
        test_random_hits();
        test_output_backpressure();

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_hits.size() == 0) begin
            $display("energy_threshold_hit_time_core: match");
        end else begin
            $display("energy_threshold_hit_time_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/etht_pkg.sv
hw/rtl/etht_isqrt.sv
hw/rtl/energy_threshold_hit_time_core.sv
dv/tb_top.sv
